@@ sv/tpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// tpwm_pkg
// Shared types and constants for the three-phase centre-aligned PWM block.
// ----------------------------------------------------------------------------
package tpwm_pkg;

  // counter width and derived compare widths
  localparam int COUNT_BITS = 16;
  localparam int DUTY_BITS  = 16;
  localparam int CMP_BITS   = (COUNT_BITS > DUTY_BITS) ? COUNT_BITS : DUTY_BITS;
  localparam int WIDE_BITS  = CMP_BITS + 1;
  localparam int NUM_PHASES = 3;

  // largest value the counter can hold, at compare width
  localparam logic [CMP_BITS-1:0] COUNT_MAX = CMP_BITS'({COUNT_BITS{1'b1}});

  // period register reset value
  localparam logic [DUTY_BITS-1:0] TOP_RESET = DUTY_BITS'(9999);

  // item commands
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_DUTY   = 2'd1,
    CMD_ENABLE = 2'd2
  } cmd_t;

  // input item
  typedef struct packed {
    cmd_t                 command;
    logic [DUTY_BITS-1:0] duty_a_in;
    logic [DUTY_BITS-1:0] duty_b_in;
    logic [DUTY_BITS-1:0] duty_c_in;
    logic                 enable_value;
  } tpwm_in_t;

  // result item
  typedef struct packed {
    logic                 phase_a_out;
    logic                 phase_b_out;
    logic                 phase_c_out;
    logic                 counting_down;
    logic                 period_start;
    logic [DUTY_BITS-1:0] duty_a_now;
    logic [DUTY_BITS-1:0] duty_b_now;
    logic [DUTY_BITS-1:0] duty_c_now;
    logic                 enabled_now;
  } tpwm_out_t;

endpackage

@@ sv/three_phase_center_aligned_pwm.sv @@
// ----------------------------------------------------------------------------
// three_phase_center_aligned_pwm
// Up/down counter with three compare lanes, buffered duty loads at both
// counter ends, enable control and a period-start marker on each return to 0.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | direction | handshake
//  --------+--------------------------------+-----------+-------------------
//  input   | in_valid, in_stall, in_data    | in        | valid / stall
//  result  | out_valid, out_stall, out_data | out       | valid / stall
//  config  | cfg_wr_en, cfg_wr_data         | in        | write enable only
//
//  One item per cycle while in_stall is low: the state update and result
//  are a single pass of compare and add logic, with the result held in an
//  output register. A skid register behind the output register lets one
//  more item be taken while a result is stalled; in_stall rises only when
//  the skid is full.
//  Synchronous active-low reset clears counter, duties, enable and valids.
//
module three_phase_center_aligned_pwm
  import tpwm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tpwm_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tpwm_out_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [DUTY_BITS-1:0] cfg_wr_data
);

  // state registers
  logic [DUTY_BITS-1:0]  period_top_r;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  down_r, down_nxt;
  logic                  enable_r, enable_nxt;
  logic [DUTY_BITS-1:0]  pending_r [NUM_PHASES];
  logic [DUTY_BITS-1:0]  pending_nxt [NUM_PHASES];
  logic [DUTY_BITS-1:0]  active_r [NUM_PHASES];
  logic [DUTY_BITS-1:0]  active_nxt [NUM_PHASES];

  // output and skid stages
  logic                  out_valid_r;
  tpwm_out_t             out_data_r;
  logic                  skid_valid_r;
  tpwm_out_t             skid_data_r;

  // datapath signals
  logic                  accept_in;
  logic                  out_taken;
  logic                  start;
  logic [CMP_BITS-1:0]   top_w;
  logic [WIDE_BITS-1:0]  up_w;
  logic [COUNT_BITS-1:0] dec_w;
  logic [DUTY_BITS-1:0]  duty_req [NUM_PHASES];
  logic [NUM_PHASES-1:0] phase_on;
  tpwm_out_t             res;

  assign accept_in = in_valid && !in_stall;
  assign out_taken = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // requested duties as lanes
  assign duty_req[0] = in_data.duty_a_in;
  assign duty_req[1] = in_data.duty_b_in;
  assign duty_req[2] = in_data.duty_c_in;

  // effective top, limited to the counter range
  always_comb begin
    top_w = CMP_BITS'(period_top_r);
    if (top_w > COUNT_MAX) begin
      top_w = COUNT_MAX;
    end
  end

  // next state for one item
  always_comb begin
    count_nxt  = count_r;
    down_nxt   = down_r;
    enable_nxt = enable_r;
    start      = 1'b0;
    up_w       = WIDE_BITS'(count_r) + WIDE_BITS'(1);
    dec_w      = (count_r != '0) ? (count_r - COUNT_BITS'(1)) : count_r;
    for (int i = 0; i < NUM_PHASES; i++) begin
      pending_nxt[i] = pending_r[i];
      active_nxt[i]  = active_r[i];
    end
    case (in_data.command)
      CMD_TICK: begin
        if (!down_r) begin
          // count up, turn at the top
          if (up_w >= WIDE_BITS'(top_w)) begin
            count_nxt = top_w[COUNT_BITS-1:0];
            down_nxt  = 1'b1;
            for (int i = 0; i < NUM_PHASES; i++) begin
              active_nxt[i] = pending_r[i];
            end
          end else begin
            count_nxt = up_w[COUNT_BITS-1:0];
          end
        end else begin
          // count down, turn at zero
          count_nxt = dec_w;
          if (dec_w == '0) begin
            down_nxt = 1'b0;
            start    = 1'b1;
            for (int i = 0; i < NUM_PHASES; i++) begin
              active_nxt[i] = pending_r[i];
            end
          end
        end
      end
      CMD_DUTY: begin
        // clamp each requested duty to the top
        for (int i = 0; i < NUM_PHASES; i++) begin
          if (CMP_BITS'(duty_req[i]) > top_w) begin
            pending_nxt[i] = top_w[DUTY_BITS-1:0];
          end else begin
            pending_nxt[i] = duty_req[i];
          end
        end
      end
      CMD_ENABLE: begin
        enable_nxt = in_data.enable_value;
        if (!in_data.enable_value) begin
          for (int i = 0; i < NUM_PHASES; i++) begin
            pending_nxt[i] = '0;
            active_nxt[i]  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result from the updated state
  always_comb begin
    for (int i = 0; i < NUM_PHASES; i++) begin
      phase_on[i] = enable_nxt &&
                    (CMP_BITS'(count_nxt) < CMP_BITS'(active_nxt[i]));
    end
    res.phase_a_out   = phase_on[0];
    res.phase_b_out   = phase_on[1];
    res.phase_c_out   = phase_on[2];
    res.counting_down = down_nxt;
    res.period_start  = start;
    res.duty_a_now    = pending_nxt[0];
    res.duty_b_now    = pending_nxt[1];
    res.duty_c_now    = pending_nxt[2];
    res.enabled_now   = enable_nxt;
  end

  // period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_top_r <= TOP_RESET;
    end else if (cfg_wr_en) begin
      period_top_r <= cfg_wr_data;
    end
  end

  // counter, direction, enable and duties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      down_r   <= 1'b0;
      enable_r <= 1'b0;
      for (int i = 0; i < NUM_PHASES; i++) begin
        pending_r[i] <= '0;
        active_r[i]  <= '0;
      end
    end else if (accept_in) begin
      count_r  <= count_nxt;
      down_r   <= down_nxt;
      enable_r <= enable_nxt;
      for (int i = 0; i < NUM_PHASES; i++) begin
        pending_r[i] <= pending_nxt[i];
        active_r[i]  <= active_nxt[i];
      end
    end
  end

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_taken) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload of the output and skid stages
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_taken) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept_in) begin
        out_data_r <= res;
      end
    end else if (accept_in) begin
      skid_data_r <= res;
    end
  end

  // skid only ever holds a result behind a full output stage
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output stage empty");

  // skid fills only when the output was held last cycle
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid stage filled without a stalled output");

  // a period start always turns the counter upwards
  a_start_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.period_start) |-> !out_data_r.counting_down)
    else $error("period start reported while counting down");

  // no phase drives while disabled
  a_phase_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.phase_a_out || out_data_r.phase_b_out ||
                     out_data_r.phase_c_out)) |-> out_data_r.enabled_now)
    else $error("phase output high while disabled");

endmodule
